### rtl/sorted_name_table_lookup_assert.svh
// Assertion macros for the sorted name table lookup checker.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef SORTED_NAME_TABLE_LOOKUP_ASSERT_SVH
`define SORTED_NAME_TABLE_LOOKUP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SNTL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sntl: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SNTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sntl: next-cycle check failed");

`endif

### rtl/sntl_pkg.sv
// Shared types, codes and helpers for the sorted name table lookup.
// No dependencies; imported by every module of the block.
`default_nettype none

package sntl_pkg;

  localparam int LIB_DEPTH_DEF  = 1024;
  localparam int DYN_DEPTH_DEF  = 16;
  localparam int NAME_CHARS_DEF = 8;

  localparam int NAME_W   = 64;
  localparam int IDX_W    = 10;
  localparam int LCNT_W   = 11;
  localparam int DCNT_W   = 5;
  localparam int CFG_W    = 11;
  localparam int CFG_IX_W = 1;

  localparam logic [CFG_IX_W-1:0] REG_LIBRARY_COUNT = 1'd0;
  localparam logic [CFG_IX_W-1:0] REG_DYNAMIC_COUNT = 1'd1;

  typedef enum logic [1:0] {
    OP_WR_LIB    = 2'd0,
    OP_WR_DYN    = 2'd1,
    OP_FIND_NAME = 2'd2,
    OP_FIND_NUM  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DYN_CMP,
    S_DYN_PICK,
    S_LIB_ADDR,
    S_LIB_CMP,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_MISS,
    RES_NUM,
    RES_DYN,
    RES_LIB
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    res_sel_t res_sel;
    logic     narrow;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dyn_hit;
    logic lo_lt_hi;
    logic lib_eq;
  } dp_stat_t;

  // keep the first chars bytes up to the first zero byte, clear the rest
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v,
                                                  input int chars);
    logic [NAME_W-1:0] r;
    logic              alive;
    logic [7:0]        b;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      b = v[NAME_W-1-8*i -: 8];
      if (i >= chars || b == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[NAME_W-1-8*i -: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/sntl_datapath.sv
// Datapath: config registers, library RAM, dynamic name registers,
// binary search bounds and result registers. Uses sntl_pkg.
`default_nettype none

module sntl_datapath #(
  parameter int LIB_DEPTH  = sntl_pkg::LIB_DEPTH_DEF,
  parameter int DYN_DEPTH  = sntl_pkg::DYN_DEPTH_DEF,
  parameter int NAME_CHARS = sntl_pkg::NAME_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sntl_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [sntl_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                    op,
  input  logic [sntl_pkg::IDX_W-1:0]    index,
  input  logic [sntl_pkg::NAME_W-1:0]   name,
  input  sntl_pkg::ctrl_cmd_t           cmd,
  output sntl_pkg::dp_stat_t            stat,
  output logic                          found,
  output logic                          is_dynamic,
  output logic [sntl_pkg::IDX_W-1:0]    result_index
);
  import sntl_pkg::*;

  localparam int LAW = (LIB_DEPTH > 1) ? $clog2(LIB_DEPTH) : 1;
  localparam int LCW = $clog2(LIB_DEPTH + 1);
  localparam int DAW = (DYN_DEPTH > 1) ? $clog2(DYN_DEPTH) : 1;

  logic [LCNT_W-1:0]    lib_count;
  logic [DCNT_W-1:0]    dyn_count;
  logic [NAME_W-1:0]    key;
  logic [LCW-1:0]       lo;
  logic [LCW-1:0]       hi;
  logic [LCW-1:0]       hi_init;
  logic [LCW:0]         mid_sum;
  logic [LAW-1:0]       mid;
  logic [LAW-1:0]       mid_q;
  logic [NAME_W-1:0]    lib_rdata;
  logic [NAME_W-1:0]    lib_norm;
  logic [NAME_W-1:0]    lib_mem [LIB_DEPTH];
  logic [NAME_W-1:0]    dyn_names [DYN_DEPTH];
  logic [DYN_DEPTH-1:0] match;
  logic [DYN_DEPTH-1:0] match_q;
  logic [DAW-1:0]       dyn_slot;
  logic                 dyn_any;
  logic                 lib_we;
  logic                 dyn_we;
  logic                 found_p;
  logic                 dyn_p;
  logic [IDX_W-1:0]     idx_p;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lib_count <= '0;
      dyn_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_LIBRARY_COUNT) begin
        lib_count <= cfg_data;
      end
      if (cfg_index == REG_DYNAMIC_COUNT) begin
        dyn_count <= cfg_data[DCNT_W-1:0];
      end
    end
  end

  assign lib_we = cmd.accept && (op == OP_WR_LIB) && (int'(index) < LIB_DEPTH);
  assign dyn_we = cmd.accept && (op == OP_WR_DYN) && (int'(index) < DYN_DEPTH);

  // library RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (lib_we) begin
      lib_mem[LAW'(index)] <= name;
    end
  end

  always_ff @(posedge clk) begin
    lib_rdata <= lib_mem[mid];
  end

  always_ff @(posedge clk) begin
    if (dyn_we) begin
      dyn_names[DAW'(index)] <= name;
    end
  end

  // search key and bounds
  assign hi_init = (int'(lib_count) >= LIB_DEPTH) ? LCW'(LIB_DEPTH) : LCW'(lib_count);
  assign mid_sum = {1'b0, lo} + {1'b0, hi} - (LCW + 1)'(1);
  assign mid     = LAW'(mid_sum[LCW:1]);
  assign lib_norm = norm_name(lib_rdata, NAME_CHARS);

  always_ff @(posedge clk) begin
    mid_q <= mid;
    if (cmd.accept) begin
      key <= norm_name(name, NAME_CHARS);
      lo  <= '0;
      hi  <= hi_init;
    end else if (cmd.narrow) begin
      if (key > lib_norm) begin
        lo <= LCW'(mid_q) + LCW'(1);
      end else begin
        hi <= LCW'(mid_q);
      end
    end
  end

  // dynamic compare, all slots at once, registered before the pick
  always_comb begin
    for (int i = 0; i < DYN_DEPTH; i++) begin
      match[i] = (i < int'(dyn_count)) && (norm_name(dyn_names[i], NAME_CHARS) == key);
    end
  end

  always_ff @(posedge clk) begin
    match_q <= match;
  end

  always_comb begin
    dyn_slot = '0;
    dyn_any  = 1'b0;
    for (int i = DYN_DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        dyn_slot = DAW'(i);
        dyn_any  = 1'b1;
      end
    end
  end

  assign stat.dyn_hit  = dyn_any;
  assign stat.lo_lt_hi = lo < hi;
  assign stat.lib_eq   = lib_norm == key;

  // pending result, then output register
  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      RES_MISS: begin
        found_p <= 1'b0;
        dyn_p   <= 1'b0;
        idx_p   <= '0;
      end
      RES_NUM: begin
        found_p <= 1'b1;
        dyn_p   <= 1'b0;
        idx_p   <= index;
      end
      RES_DYN: begin
        found_p <= 1'b1;
        dyn_p   <= 1'b1;
        idx_p   <= IDX_W'(dyn_slot);
      end
      RES_LIB: begin
        found_p <= 1'b1;
        dyn_p   <= 1'b0;
        idx_p   <= IDX_W'(mid_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found        <= found_p;
      is_dynamic   <= dyn_p;
      result_index <= idx_p;
    end
  end

endmodule

`default_nettype wire

### rtl/sntl_ctrl.sv
// Controller state machine: sequences accept, dynamic scan, binary search
// probes and result hand-off. Uses sntl_pkg; drives the datapath commands.
`default_nettype none

module sntl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic                scan_dyn,
  output logic                out_valid,
  input  logic                out_ready,
  input  sntl_pkg::dp_stat_t  stat,
  output sntl_pkg::ctrl_cmd_t cmd
);
  import sntl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.res_sel  = RES_NONE;
    cmd.narrow   = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (op_t'(op))
            OP_FIND_NUM: begin
              cmd.res_sel = RES_NUM;
              state_next  = S_FINISH;
            end
            OP_FIND_NAME: begin
              state_next = scan_dyn ? S_DYN_CMP : S_LIB_ADDR;
            end
            default: begin
            end
          endcase
        end
      end
      S_DYN_CMP: begin
        state_next = S_DYN_PICK;
      end
      S_DYN_PICK: begin
        if (stat.dyn_hit) begin
          cmd.res_sel = RES_DYN;
          state_next  = S_FINISH;
        end else begin
          state_next = S_LIB_ADDR;
        end
      end
      S_LIB_ADDR: begin
        if (!stat.lo_lt_hi) begin
          cmd.res_sel = RES_MISS;
          state_next  = S_FINISH;
        end else begin
          state_next = S_LIB_CMP;
        end
      end
      S_LIB_CMP: begin
        if (stat.lib_eq) begin
          cmd.res_sel = RES_LIB;
          state_next  = S_FINISH;
        end else begin
          cmd.narrow = 1'b1;
          state_next = S_LIB_ADDR;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sorted_name_table_lookup.sv
// Sequence, accept cycle to first out_valid cycle: a by-number lookup goes to the finish state;
// a name lookup does the dynamic compare and pick (scan_dyn set), then library probes (RAM
// address, then compare on the registered word), then finish, also on a miss. Writes are done
// in the accept cycle and give no result. Throughput: one item at a time, the next taken as the
// result shows; a 1024-entry library needs at most 11 probes; finish waits out any output stall.
// Reset (rst, synchronous): counts clear, state idle, no result pending; tables keep contents.
//
// Top level of the sorted name table lookup. Depends on sntl_pkg, sntl_ctrl
// and sntl_datapath.
`default_nettype none

module sorted_name_table_lookup #(
  parameter int LIB_DEPTH  = sntl_pkg::LIB_DEPTH_DEF,
  parameter int DYN_DEPTH  = sntl_pkg::DYN_DEPTH_DEF,
  parameter int NAME_CHARS = sntl_pkg::NAME_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes: index 0 library_count, index 1 dynamic_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sntl_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [sntl_pkg::CFG_W-1:0]    cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [sntl_pkg::IDX_W-1:0]    index,
  input  logic [sntl_pkg::NAME_W-1:0]   name,
  input  logic                          scan_dyn,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic                          is_dynamic,
  output logic [sntl_pkg::IDX_W-1:0]    result_index
);
  import sntl_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Config registers are plain flops, so the channel never stalls. The user
  // must issue writes only while the block is idle; the block does not enforce this.
  assign cfg_ready = 1'b1;

  // Controller: one item in flight; the output register lets a new item
  // be accepted while the previous result still waits for a transfer.
  sntl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .scan_dyn   (scan_dyn),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: library RAM with registered read, dynamic name flops with
  // a full-width parallel compare, search bounds and result registers.
  sntl_datapath #(
    .LIB_DEPTH  (LIB_DEPTH),
    .DYN_DEPTH  (DYN_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .index        (index),
    .name         (name),
    .cmd          (cmd),
    .stat         (stat),
    .found        (found),
    .is_dynamic   (is_dynamic),
    .result_index (result_index)
  );

endmodule

`default_nettype wire

### rtl/sntl_checker.sv
// Port-level checker for sorted_name_table_lookup, attached by bind.
// Depends on sntl_pkg and sorted_name_table_lookup_assert.svh.
`default_nettype none
`include "sorted_name_table_lookup_assert.svh"

module sntl_checker #(
  parameter int DYN_DEPTH = sntl_pkg::DYN_DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       found,
  input logic                       is_dynamic,
  input logic [sntl_pkg::IDX_W-1:0] result_index
);
  import sntl_pkg::*;

  // a stalled result holds
  `SNTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_index) && $stable(found) && $stable(is_dynamic))

  // a miss carries zero fields
  `SNTL_ASSERT_NOW(a_miss_zero, out_valid && !found, !is_dynamic && (result_index == '0))

  // dynamic hits name a real slot
  `SNTL_ASSERT_NOW(a_dyn_slot, out_valid && is_dynamic, found && (int'(result_index) < DYN_DEPTH))

  // a lookup occupies the block for at least the following cycle
  `SNTL_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && (op == OP_FIND_NAME || op == OP_FIND_NUM), !in_ready)

endmodule

bind sorted_name_table_lookup sntl_checker #(.DYN_DEPTH(DYN_DEPTH)) u_sntl_checker (.*);

`default_nettype wire
